/* rtl/ptwa_pkg.sv */
package ptwa_pkg;

    localparam int ADDR_W  = 32;
    localparam int NAME_W  = 64;
    localparam int AGE_W   = 16;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 3;
    localparam int MAX_OUT = 16;

    localparam logic [AGE_W-1:0] TTL_RESET = 16'd5000;
    localparam logic [AGE_W-1:0] AGE_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_LIST   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_REFRESHED = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_DROPPED   = 3'd2,
        STAT_LISTED    = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  addr;
        logic [NAME_W-1:0]  name;
        logic               last;
    } res_t;

    typedef struct packed {
        logic addr_we;
        logic name_we;
        logic age_we;
    } st_we_t;

endpackage

/* rtl/peer_table_with_aging_top.sv */
// Peer table with aging: up to ENTRIES peers keyed by a 32-bit address, each with a
// packed name (low NAME_BYTES bytes kept) and a 16-bit age. One transaction on the
// slave side carries one operation in s_tuser: upsert (one result, status refreshed,
// inserted or dropped), tick (no result), list (retires peers older than ttl_ticks,
// then returns up to max_count peers in slot order, or one list-empty result) and
// clear (no result). Every operation but clear walks the table one slot at a time
// through a store with one read and one write port whose read data is registered; an
// upsert that matches stops at that slot, and a stall on the master side holds the walk.
// s_tready is low while an item is being worked on. ttl_ticks resets to 5000 and is
// written through cfg_wen/cfg_wdata; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module peer_table_with_aging_top #(
    parameter int ENTRIES    = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // peer_addr[31:0], peer_name[95:32], max_count[100:96]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_addr[31:0], out_name[95:32]
    output logic [2:0]   m_tuser,   // status[2:0]
    output logic         m_tlast,
    input  logic         cfg_wen,
    input  logic [15:0]  cfg_wdata
);
    import ptwa_pkg::*;

    logic [AGE_W-1:0] ttl_reg;
    logic             m_tvalid_reg;
    res_t             out_reg;
    logic             res_valid;
    logic             res_ready;
    res_t             res;

    assign res_ready = !m_tvalid_reg || m_tready;

    ptwa_ctrl #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_addr   (s_tdata[31:0]),
        .in_name   (s_tdata[95:32]),
        .in_maxc   (s_tdata[100:96]),
        .ttl       (ttl_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg      <= TTL_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                ttl_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                m_tvalid_reg <= res_valid;
            end
        end
    end

    // output transaction register
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.name, out_reg.addr};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

/* rtl/ptwa_store.sv */
module ptwa_store #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4,
    parameter int NB_W    = 64
) (
    input  logic                        clk,
    input  logic [IDX_W-1:0]            rd_idx,
    output logic [ptwa_pkg::ADDR_W-1:0] rd_addr_reg,
    output logic [NB_W-1:0]             rd_name_reg,
    output logic [ptwa_pkg::AGE_W-1:0]  rd_age_reg,
    input  ptwa_pkg::st_we_t            we,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [ptwa_pkg::ADDR_W-1:0] wr_addr,
    input  logic [NB_W-1:0]             wr_name,
    input  logic [ptwa_pkg::AGE_W-1:0]  wr_age
);
    import ptwa_pkg::*;

    logic [ADDR_W-1:0] addr_mem [ENTRIES];
    logic [NB_W-1:0]   name_mem [ENTRIES];
    logic [AGE_W-1:0]  age_mem  [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we.addr_we)
        begin
            addr_mem[wr_idx] <= wr_addr;
        end
        if (we.name_we)
        begin
            name_mem[wr_idx] <= wr_name;
        end
        if (we.age_we)
        begin
            age_mem[wr_idx] <= wr_age;
        end
        rd_addr_reg <= addr_mem[rd_idx];
        rd_name_reg <= name_mem[rd_idx];
        rd_age_reg  <= age_mem[rd_idx];
    end

endmodule

/* rtl/ptwa_ctrl.sv */
module ptwa_ctrl #(
    parameter int ENTRIES    = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ptwa_pkg::op_t               in_op,
    input  logic [ptwa_pkg::ADDR_W-1:0] in_addr,
    input  logic [ptwa_pkg::NAME_W-1:0] in_name,
    input  logic [ptwa_pkg::CNT_W-1:0]  in_maxc,
    input  logic [ptwa_pkg::AGE_W-1:0]  ttl,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ptwa_pkg::res_t              res
);
    import ptwa_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NB_W  = 8 * NAME_BYTES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [ADDR_W-1:0]   key_addr_reg;
    logic [NB_W-1:0]     key_name_reg;
    logic [CNT_W-1:0]    maxc_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                free_found_reg;
    logic                held_valid_reg;
    logic [ADDR_W-1:0]   held_addr_reg;
    logic [NB_W-1:0]     held_name_reg;
    logic [ENTRIES-1:0]  active_reg;

    logic [ADDR_W-1:0]   rd_addr;
    logic [NB_W-1:0]     rd_name;
    logic [AGE_W-1:0]    rd_age;
    st_we_t              we;
    logic [IDX_W-1:0]    wr_idx;
    logic [NB_W-1:0]     wr_name;
    logic [AGE_W-1:0]    wr_age;

    logic                act;
    logic                key_hit;
    logic                expired;
    logic                step;
    logic [CNT_W-1:0]    maxc_clamped;

    ptwa_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .NB_W    (NB_W)
    ) u_store (
        .clk         (clk),
        .rd_idx      (idx_reg),
        .rd_addr_reg (rd_addr),
        .rd_name_reg (rd_name),
        .rd_age_reg  (rd_age),
        .we          (we),
        .wr_idx      (wr_idx),
        .wr_addr     (key_addr_reg),
        .wr_name     (wr_name),
        .wr_age      (wr_age)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign act          = active_reg[idx_reg];
    assign key_hit      = act && (rd_addr == key_addr_reg);
    assign expired      = act && (rd_age > ttl);
    assign maxc_clamped = (in_maxc > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : in_maxc;

    // shared per-slot unit: one compare/increment per evaluated slot
    always_comb
    begin
        res_valid   = 1'b0;
        res.status  = STAT_EMPTY;
        res.addr    = '0;
        res.name    = '0;
        res.last    = 1'b1;
        we          = '0;
        wr_idx      = idx_reg;
        wr_name     = key_name_reg;
        wr_age      = '0;
        step        = 1'b0;
        unique case (state_reg)
            S_EVAL:
            begin
                case (op_reg)
                    OP_UPSERT:
                    begin
                        if (key_hit)
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_REFRESHED;
                            we.name_we = res_ready;
                            we.age_we  = res_ready;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        step      = 1'b1;
                        wr_age    = rd_age + AGE_W'(1);
                        we.age_we = act && (rd_age != AGE_MAX);
                    end
                    OP_LIST:
                    begin
                        if (!expired && act && (cnt_reg < maxc_reg) && held_valid_reg)
                        begin
                            // the peer held back is not the final one
                            res_valid  = 1'b1;
                            res.status = STAT_LISTED;
                            res.addr   = held_addr_reg;
                            res.name   = NAME_W'(held_name_reg);
                            res.last   = 1'b0;
                            step       = res_ready;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                    default:
                    begin
                        step = 1'b1;
                    end
                endcase
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (op_reg == OP_UPSERT)
                begin
                    if (free_found_reg)
                    begin
                        res.status = STAT_INSERTED;
                        wr_idx     = free_idx_reg;
                        we.addr_we = res_ready;
                        we.name_we = res_ready;
                        we.age_we  = res_ready;
                    end
                    else
                    begin
                        res.status = STAT_DROPPED;
                    end
                end
                else if (held_valid_reg)
                begin
                    res.status = STAT_LISTED;
                    res.addr   = held_addr_reg;
                    res.name   = NAME_W'(held_name_reg);
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= '0;
            op_reg         <= OP_UPSERT;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= in_op;
                        key_addr_reg   <= in_addr;
                        key_name_reg   <= in_name[NB_W-1:0];
                        maxc_reg       <= maxc_clamped;
                        idx_reg        <= '0;
                        cnt_reg        <= '0;
                        free_found_reg <= 1'b0;
                        held_valid_reg <= 1'b0;
                        if (in_op == OP_CLEAR)
                        begin
                            active_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (op_reg == OP_UPSERT && key_hit)
                    begin
                        if (res_ready)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (step)
                    begin
                        if (op_reg == OP_UPSERT && !act && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= idx_reg;
                        end
                        if (op_reg == OP_LIST)
                        begin
                            if (expired)
                            begin
                                active_reg[idx_reg] <= 1'b0;
                            end
                            else if (act && (cnt_reg < maxc_reg))
                            begin
                                held_valid_reg <= 1'b1;
                                held_addr_reg  <= rd_addr;
                                held_name_reg  <= rd_name;
                                cnt_reg        <= cnt_reg + CNT_W'(1);
                            end
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= (op_reg == OP_TICK) ? S_IDLE : S_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (res_ready)
                    begin
                        if (op_reg == OP_UPSERT && free_found_reg)
                        begin
                            active_reg[free_idx_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* dv/tb_peer_table_with_aging_top.sv */
`timescale 1ns / 1ps

module tb_peer_table_with_aging_top;
    import ptwa_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int NAME_BYTES    = 8;
    localparam logic [NAME_W-1:0] NAME_MASK = {NAME_W{1'b1}} >> (64 - 8 * NAME_BYTES);
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 10;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int POOL_SIZE     = 20;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // peer_addr[31:0], peer_name[95:32], max_count[100:96]
    logic [1:0]   s_tuser;   // operation[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // out_addr[31:0], out_name[95:32]
    logic [2:0]   m_tuser;   // status[2:0]
    logic         m_tlast;
    logic         cfg_wen;
    logic [15:0]  cfg_wdata;

    // own copy of the peer table
    logic              tbl_active [ENTRIES];
    logic [ADDR_W-1:0] tbl_addr   [ENTRIES];
    logic [NAME_W-1:0] tbl_name   [ENTRIES];
    logic [AGE_W-1:0]  tbl_age    [ENTRIES];
    logic [AGE_W-1:0]  ttl_q;

    res_t              peer_results_q [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int                err_count;
    int                cycle_count;
    bit                idle_en;

    peer_table_with_aging_top #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic res_t make_res(status_t st, logic [ADDR_W-1:0] a,
                                      logic [NAME_W-1:0] n, logic l);
        res_t r;
        r.status = st;
        r.addr   = a;
        r.name   = n;
        r.last   = l;
        return r;
    endfunction

    task automatic predict_peer_op(input op_t op, input logic [ADDR_W-1:0] addr,
                                   input logic [NAME_W-1:0] name, input logic [CNT_W-1:0] maxc);
        int slot;
        int limit;
        int total;
        int k;
        int i;
        logic [NAME_W-1:0] kept;
        kept = name & NAME_MASK;
        case (op)
            OP_UPSERT:
            begin
                slot = -1;
                for (i = 0; i < ENTRIES; i++)
                    if (slot < 0 && tbl_active[i] && tbl_addr[i] == addr)
                        slot = i;
                if (slot >= 0)
                begin
                    tbl_name[slot] = kept;
                    tbl_age[slot]  = '0;
                    peer_results_q.push_back(make_res(STAT_REFRESHED, '0, '0, 1'b1));
                end
                else
                begin
                    for (i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !tbl_active[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        tbl_active[slot] = 1'b1;
                        tbl_addr[slot]   = addr;
                        tbl_name[slot]   = kept;
                        tbl_age[slot]    = '0;
                        peer_results_q.push_back(make_res(STAT_INSERTED, '0, '0, 1'b1));
                    end
                    else
                        peer_results_q.push_back(make_res(STAT_DROPPED, '0, '0, 1'b1));
                end
            end
            OP_TICK:
            begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_active[i] && tbl_age[i] != AGE_MAX)
                        tbl_age[i] = tbl_age[i] + 1'b1;
            end
            OP_CLEAR:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    tbl_active[i] = 1'b0;
                    tbl_addr[i]   = '0;
                    tbl_name[i]   = '0;
                    tbl_age[i]    = '0;
                end
            end
            default:
            begin
                // expiry pass comes before the listing
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_active[i] && tbl_age[i] > ttl_q)
                        tbl_active[i] = 1'b0;
                limit = (maxc > MAX_OUT) ? MAX_OUT : int'(maxc);
                total = 0;
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_active[i] && total < limit)
                        total++;
                if (total == 0)
                    peer_results_q.push_back(make_res(STAT_EMPTY, '0, '0, 1'b1));
                else
                begin
                    k = 0;
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        if (tbl_active[i] && k < total)
                        begin
                            k++;
                            peer_results_q.push_back(make_res(STAT_LISTED, tbl_addr[i],
                                                              tbl_name[i], k == total));
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        err_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    task automatic check_peer_result();
        res_t want;
        if (peer_results_q.size() == 0)
        begin
            err_count++;
            $display("%0t: result with nothing expected, actual status %0d addr %h",
                     $time, m_tuser, m_tdata[31:0]);
            $display("%0t: actual name %h last %b", $time, m_tdata[95:32], m_tlast);
        end
        else
        begin
            want = peer_results_q.pop_front();
            if (m_tuser !== want.status)
                note_mismatch("status", 64'(want.status), 64'(m_tuser));
            if (m_tdata[31:0] !== want.addr)
                note_mismatch("out_addr", 64'(want.addr), 64'(m_tdata[31:0]));
            if (m_tdata[95:32] !== want.name)
                note_mismatch("out_name", want.name, m_tdata[95:32]);
            if (m_tlast !== want.last)
                note_mismatch("last", 64'(want.last), 64'(m_tlast));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            check_peer_result();
    end

    // receiver back-pressure
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 4) == 0)
            begin
                m_tready = 1'b0;
                n = $urandom_range(1, 7);
                repeat (n) @(negedge clk);
                m_tready = 1'b1;
            end
            else
                m_tready = 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_peer_table_with_aging_top failed");
        $finish;
    end

    task automatic send_item(input op_t op, input logic [ADDR_W-1:0] addr,
                             input logic [NAME_W-1:0] name, input logic [CNT_W-1:0] maxc);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {3'b000, maxc, name, addr};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        predict_peer_op(op, addr, name, maxc);
    endtask

    // lower valid, let every result drain and give a trailing tick time to finish
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (peer_results_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_ttl(input logic [AGE_W-1:0] value);
        wait_idle();
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen   = 1'b0;
        ttl_q     = value;
    endtask

    // ttl left at its reset value: a peer a few ticks old is still listed
    task automatic test_reset_ttl_expiry();
        send_item(OP_UPSERT, 32'hC0A8_0001, 64'h0000_6F6C_6C65_68, 5'd0);
        send_item(OP_UPSERT, 32'hC0A8_0001, 64'h0000_0000_6269_6F62, 5'd0);
        repeat (8) send_item(OP_TICK, $urandom, {$urandom, $urandom}, 5'd16);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd16);
        send_item(OP_TICK, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd5);
    endtask

    task automatic test_directed();
        int i;
        send_item(OP_CLEAR, 32'hFFFF_FFFF, {64{1'b1}}, 5'd31);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd16);
        send_item(OP_UPSERT, 32'h0, 64'h0, 5'd0);
        send_item(OP_UPSERT, 32'hFFFF_FFFF, {64{1'b1}}, 5'd31);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd31);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd1);
        send_item(OP_UPSERT, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0, 5'd0);
        // fill the table, then one more peer is dropped
        for (i = 0; i < ENTRIES - 2; i++)
            send_item(OP_UPSERT, 32'h0A00_0000 + i, {$urandom, $urandom}, 5'd0);
        send_item(OP_UPSERT, 32'h0B00_0001, {$urandom, $urandom}, 5'd0);
        send_item(OP_UPSERT, 32'hFFFF_FFFF, 64'h1234_5678_9ABC_DEF0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd16);
        send_item(OP_CLEAR, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd16);
    endtask

    task automatic test_ttl_extremes();
        write_ttl(16'd0);
        send_item(OP_UPSERT, 32'h1000_0001, {$urandom, $urandom}, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd4);
        send_item(OP_TICK, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd4);
        write_ttl(16'd1);
        send_item(OP_UPSERT, 32'h1000_0002, {$urandom, $urandom}, 5'd0);
        send_item(OP_TICK, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd4);
        send_item(OP_TICK, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd4);
        write_ttl(16'hFFFF);
        send_item(OP_UPSERT, 32'h1000_0003, {$urandom, $urandom}, 5'd0);
        repeat (3) send_item(OP_TICK, 32'h0, 64'h0, 5'd0);
        send_item(OP_LIST, 32'h0, 64'h0, 5'd16);
    endtask

    task automatic test_random();
        int phase;
        int n;
        int r;
        op_t op;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0] maxc;
        logic [AGE_W-1:0] ttl_pick;
        for (phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 4))
                0:       ttl_pick = 16'd0;
                1:       ttl_pick = 16'hFFFF;
                2:       ttl_pick = 16'($urandom);
                default: ttl_pick = 16'($urandom_range(1, 8));
            endcase
            write_ttl(ttl_pick);
            // the final phase runs with no idling on either side
            idle_en = (phase != 5);
            for (n = 0; n < 36; n++)
            begin
                if (phase == 2 && n == 18)
                    wait_idle();
                r = $urandom_range(0, 99);
                if (r < 40)
                    op = OP_UPSERT;
                else if (r < 70)
                    op = OP_TICK;
                else if (r < 95)
                    op = OP_LIST;
                else
                    op = OP_CLEAR;
                if ($urandom_range(0, 9) == 0)
                    addr = $urandom;
                else
                    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 4) == 0)
                    maxc = 5'($urandom_range(17, 31));
                else
                    maxc = 5'($urandom_range(0, 16));
                send_item(op, addr, {$urandom, $urandom}, maxc);
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_UPSERT;
        m_tready  = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        idle_en   = 1'b1;
        err_count = 0;
        ttl_q     = TTL_RESET;
        predict_peer_op(OP_CLEAR, '0, '0, '0);
        for (i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_reset_ttl_expiry();
        test_directed();
        test_ttl_extremes();
        test_random();
        wait_idle();

        if (err_count == 0)
            $display("tb_peer_table_with_aging_top passed");
        else
            $display("tb_peer_table_with_aging_top failed");
        $finish;
    end

endmodule
